/* rtl/hmt_pkg.sv */
// shared types, codes and helper functions of the height masked thinning block
// no dependencies
package hmt_pkg;

  localparam int MAX_DIM_DEF     = 256;
  localparam int MAX_CELLS_DEF   = 65536;
  localparam int HEIGHT_BITS_DEF = 24;

  localparam int DIM_BITS   = 9;
  localparam int STEP_BITS  = 24;
  localparam int PADDR_BITS = 4;
  localparam int PDATA_BITS = 32;

  localparam logic signed [STEP_BITS-1:0] MAX_STEP_RESET = 24'sd256;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_STEP    = 2'd2;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic REPLY_STATUS = 1'b0;
  localparam logic REPLY_READ   = 1'b1;

  localparam logic [1:0] STATUS_CONVERGED = 2'd0;
  localparam logic [1:0] STATUS_INVALID   = 2'd1;
  localparam logic [1:0] STATUS_LIMIT     = 2'd2;

  localparam int SUM_MIN = 2;
  localparam int SUM_MAX = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_COPY,
    S_DECIDE,
    S_APPLY
  } hmt_state_t;

  typedef struct packed {
    logic h_we;
    logic s_we;
    logic s_wdata;
    logic m_we;
    logic m_wdata;
  } mem_ctl_t;

  typedef struct packed {
    logic c_neg;
    logic c_pos;
    logic r_neg;
    logic r_pos;
  } dir_t;

  function automatic dir_t dir_of(input logic [2:0] d);
    dir_t r;
    r = '0;
    unique case (d)
      3'd0: r.r_neg = 1'b1;
      3'd1: begin r.c_pos = 1'b1; r.r_neg = 1'b1; end
      3'd2: r.c_pos = 1'b1;
      3'd3: begin r.c_pos = 1'b1; r.r_pos = 1'b1; end
      3'd4: r.r_pos = 1'b1;
      3'd5: begin r.c_neg = 1'b1; r.r_pos = 1'b1; end
      3'd6: r.c_neg = 1'b1;
      3'd7: begin r.c_neg = 1'b1; r.r_neg = 1'b1; end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic thin_remove(input logic [7:0] p, input logic pass);
    logic [3:0] sum;
    logic [3:0] trans;
    logic       side;
    sum   = '0;
    trans = '0;
    for (int d = 0; d < 8; d++) begin
      sum = sum + 4'(p[d]);
      if (!p[d] && p[(d + 1) % 8]) trans = trans + 4'd1;
    end
    if (!pass) side = !(p[0] && p[2] && p[4]) && !(p[2] && p[4] && p[6]);
    else side = !(p[0] && p[2] && p[6]) && !(p[0] && p[4] && p[6]);
    return (sum >= 4'(SUM_MIN)) && (sum <= 4'(SUM_MAX)) && (trans == 4'd1) && side;
  endfunction

endpackage

/* rtl/height_masked_thinning_top.sv */
// Zhang-Suen thinning of a road mask where neighbours beyond the height step
// limit count as absent. A valid run takes the item, copies the road mask,
// then per pass decides removals (centre and eight neighbours come one per
// cycle through the single read port of the height and skeleton memories)
// and applies them, two passes per iteration, up to max(width, height)
// iterations.
// No item is taken while a run or read is at work.
// top level: holds hmt_cfg, hmt_ctrl, hmt_store; depends on hmt_pkg
module height_masked_thinning_top #(
  parameter int MAX_DIM     = hmt_pkg::MAX_DIM_DEF,
  parameter int MAX_CELLS   = hmt_pkg::MAX_CELLS_DEF,
  parameter int HEIGHT_BITS = hmt_pkg::HEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic [15:0]                       in_cell_index,
  input  logic                              in_road,
  input  logic signed [HEIGHT_BITS-1:0]     in_height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_reply_kind,
  output logic [1:0]                        out_status,
  output logic [8:0]                        out_iterations_used,
  output logic                              out_skeleton_bit,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hmt_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [hmt_pkg::PDATA_BITS-1:0]    pwdata,
  output logic [hmt_pkg::PDATA_BITS-1:0]    prdata,
  output logic                              pready
);

  localparam int AW = $clog2(MAX_CELLS);

  logic [hmt_pkg::DIM_BITS-1:0]         grid_width;
  logic [hmt_pkg::DIM_BITS-1:0]         grid_height;
  logic signed [hmt_pkg::STEP_BITS-1:0] max_step;
  hmt_pkg::mem_ctl_t                    mc;
  logic [AW-1:0]                        h_waddr, h_raddr, s_waddr, s_raddr;
  logic [AW-1:0]                        m_waddr, m_raddr;
  logic [HEIGHT_BITS:0]                 h_wdata, h_rdata;
  logic                                 s_rdata, m_rdata;

  hmt_cfg u_cfg (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .grid_width(grid_width), .grid_height(grid_height), .max_step(max_step)
  );

  hmt_ctrl #(
    .MAX_DIM(MAX_DIM), .MAX_CELLS(MAX_CELLS), .HEIGHT_BITS(HEIGHT_BITS)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_cell_index(in_cell_index), .in_road(in_road), .in_height(in_height),
    .out_valid(out_valid), .out_stall(out_stall), .out_reply_kind(out_reply_kind),
    .out_status(out_status), .out_iterations_used(out_iterations_used),
    .out_skeleton_bit(out_skeleton_bit),
    .grid_width(grid_width), .grid_height(grid_height), .max_step(max_step),
    .mc(mc), .h_waddr(h_waddr), .h_wdata(h_wdata), .h_raddr(h_raddr), .h_rdata(h_rdata),
    .s_waddr(s_waddr), .s_raddr(s_raddr), .s_rdata(s_rdata),
    .m_waddr(m_waddr), .m_raddr(m_raddr), .m_rdata(m_rdata)
  );

  hmt_store #(
    .MAX_CELLS(MAX_CELLS), .HEIGHT_BITS(HEIGHT_BITS)
  ) u_store (
    .clk(clk), .mc(mc),
    .h_waddr(h_waddr), .h_wdata(h_wdata), .h_raddr(h_raddr), .h_rdata(h_rdata),
    .s_waddr(s_waddr), .s_raddr(s_raddr), .s_rdata(s_rdata),
    .m_waddr(m_waddr), .m_raddr(m_raddr), .m_rdata(m_rdata)
  );

endmodule

/* rtl/hmt_cfg.sv */
// apb configuration registers: grid width, grid height, step limit
// depends on hmt_pkg
module hmt_cfg (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [hmt_pkg::PADDR_BITS-1:0]          paddr,
  input  logic [hmt_pkg::PDATA_BITS-1:0]          pwdata,
  output logic [hmt_pkg::PDATA_BITS-1:0]          prdata,
  output logic                                    pready,
  output logic [hmt_pkg::DIM_BITS-1:0]            grid_width,
  output logic [hmt_pkg::DIM_BITS-1:0]            grid_height,
  output logic signed [hmt_pkg::STEP_BITS-1:0]    max_step
);

  logic [hmt_pkg::DIM_BITS-1:0]         width_r;
  logic [hmt_pkg::DIM_BITS-1:0]         height_r;
  logic signed [hmt_pkg::STEP_BITS-1:0] step_r;
  logic                                 wr;
  logic [1:0]                           reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      step_r   <= hmt_pkg::MAX_STEP_RESET;
    end else if (wr) begin
      unique case (reg_idx)
        hmt_pkg::REG_GRID_WIDTH:  width_r  <= pwdata[hmt_pkg::DIM_BITS-1:0];
        hmt_pkg::REG_GRID_HEIGHT: height_r <= pwdata[hmt_pkg::DIM_BITS-1:0];
        hmt_pkg::REG_MAX_STEP:    step_r   <= pwdata[hmt_pkg::STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      hmt_pkg::REG_GRID_WIDTH:  prdata = hmt_pkg::PDATA_BITS'(width_r);
      hmt_pkg::REG_GRID_HEIGHT: prdata = hmt_pkg::PDATA_BITS'(height_r);
      hmt_pkg::REG_MAX_STEP:    prdata = hmt_pkg::PDATA_BITS'(unsigned'(step_r));
      default: prdata = '0;
    endcase
  end

  assign grid_width  = width_r;
  assign grid_height = height_r;
  assign max_step    = step_r;

endmodule

/* rtl/hmt_store.sv */
// cell memories: road and height, skeleton, removal marks
// depends on hmt_pkg
module hmt_store #(
  parameter int MAX_CELLS   = hmt_pkg::MAX_CELLS_DEF,
  parameter int HEIGHT_BITS = hmt_pkg::HEIGHT_BITS_DEF,
  localparam int AW = $clog2(MAX_CELLS)
) (
  input  logic                   clk,
  input  hmt_pkg::mem_ctl_t      mc,
  input  logic [AW-1:0]          h_waddr,
  input  logic [HEIGHT_BITS:0]   h_wdata,
  input  logic [AW-1:0]          h_raddr,
  output logic [HEIGHT_BITS:0]   h_rdata,
  input  logic [AW-1:0]          s_waddr,
  input  logic [AW-1:0]          s_raddr,
  output logic                   s_rdata,
  input  logic [AW-1:0]          m_waddr,
  input  logic [AW-1:0]          m_raddr,
  output logic                   m_rdata
);

  logic [HEIGHT_BITS:0] h_mem [MAX_CELLS];
  logic                 s_mem [MAX_CELLS];
  logic                 m_mem [MAX_CELLS];

  always_ff @(posedge clk) begin
    if (mc.h_we) h_mem[h_waddr] <= h_wdata;
    h_rdata <= h_mem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (mc.s_we) s_mem[s_waddr] <= mc.s_wdata;
    s_rdata <= s_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (mc.m_we) m_mem[m_waddr] <= mc.m_wdata;
    m_rdata <= m_mem[m_raddr];
  end

endmodule

/* rtl/hmt_ctrl.sv */
// item handling and thinning sequencer: copy sweep, decide sweep, apply sweep
// depends on hmt_pkg, drives the memories in hmt_store
module hmt_ctrl #(
  parameter int MAX_DIM     = hmt_pkg::MAX_DIM_DEF,
  parameter int MAX_CELLS   = hmt_pkg::MAX_CELLS_DEF,
  parameter int HEIGHT_BITS = hmt_pkg::HEIGHT_BITS_DEF,
  localparam int AW = $clog2(MAX_CELLS),
  localparam int CW = $clog2(MAX_CELLS + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_kind,
  input  logic [15:0]                           in_cell_index,
  input  logic                                  in_road,
  input  logic signed [HEIGHT_BITS-1:0]         in_height,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_reply_kind,
  output logic [1:0]                            out_status,
  output logic [8:0]                            out_iterations_used,
  output logic                                  out_skeleton_bit,
  input  logic [hmt_pkg::DIM_BITS-1:0]          grid_width,
  input  logic [hmt_pkg::DIM_BITS-1:0]          grid_height,
  input  logic signed [hmt_pkg::STEP_BITS-1:0]  max_step,
  output hmt_pkg::mem_ctl_t                     mc,
  output logic [AW-1:0]                         h_waddr,
  output logic [HEIGHT_BITS:0]                  h_wdata,
  output logic [AW-1:0]                         h_raddr,
  input  logic [HEIGHT_BITS:0]                  h_rdata,
  output logic [AW-1:0]                         s_waddr,
  output logic [AW-1:0]                         s_raddr,
  input  logic                                  s_rdata,
  output logic [AW-1:0]                         m_waddr,
  output logic [AW-1:0]                         m_raddr,
  input  logic                                  m_rdata
);

  localparam int DB = hmt_pkg::DIM_BITS;

  hmt_pkg::hmt_state_t state_r, state_nxt;

  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          ai_r, ai_nxt;
  logic                   pend_r, pend_nxt;
  logic [AW-1:0]          pa_r, pa_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [DB-1:0]          col_r, col_nxt;
  logic [DB-1:0]          row_r, row_nxt;
  logic [3:0]             step_r, step_nxt;
  logic                   inb_r, inb_nxt;
  logic [HEIGHT_BITS-1:0] ctr_h_r, ctr_h_nxt;
  logic                   ctr_s_r, ctr_s_nxt;
  logic [7:0]             p_r, p_nxt;
  logic                   pass_r, pass_nxt;
  logic                   any_r, any_nxt;
  logic [8:0]             iter_r, iter_nxt;
  logic [CW-1:0]          filled_r, filled_nxt;
  logic                   rd_ok_r, rd_ok_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  logic [8:0]             out_iter_r, out_iter_nxt;
  logic                   out_skel_r, out_skel_nxt;

  logic                   accept;
  logic                   in_range;
  logic [2*DB-1:0]        prod;
  logic                   cfg_ok;
  logic [DB-1:0]          limit;
  logic                   issue;
  logic                   sweep_done;
  logic [2:0]             d_issue;
  logic [2:0]             d_data;
  hmt_pkg::dir_t          dir;
  logic [AW-1:0]          wv;
  logic [AW-1:0]          n_addr;
  logic                   n_inb;
  logic [HEIGHT_BITS:0]   diff;
  logic [HEIGHT_BITS:0]   adiff;
  logic                   pres;
  logic [7:0]             p_full;
  logic                   rem;
  logic                   last_cell;
  logic [9:0]             iter_inc;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != hmt_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign in_range  = 32'(in_cell_index) < 32'(MAX_CELLS);
  assign prod      = grid_width * grid_height;
  assign cfg_ok    = (grid_width >= DB'(3)) && (grid_height >= DB'(3)) &&
                     (32'(grid_width) <= 32'(MAX_DIM)) && (32'(grid_height) <= 32'(MAX_DIM)) &&
                     !max_step[hmt_pkg::STEP_BITS-1] && (max_step != '0) &&
                     (32'(prod) <= 32'(MAX_CELLS));
  assign limit     = (grid_width > grid_height) ? grid_width : grid_height;
  assign issue     = ai_r < cnt_r;
  assign sweep_done = !issue && !pend_r;
  assign iter_inc  = 10'(iter_r) + 10'd1;

  // neighbour fetch address and bounds
  assign d_issue = 3'(step_r - 4'd1);
  assign d_data  = 3'(step_r - 4'd2);
  assign dir     = hmt_pkg::dir_of(d_issue);
  assign wv      = AW'(grid_width);
  always_comb begin
    n_addr = idx_r;
    if (dir.r_neg) n_addr = n_addr - wv;
    if (dir.r_pos) n_addr = n_addr + wv;
    if (dir.c_neg) n_addr = n_addr - AW'(1);
    if (dir.c_pos) n_addr = n_addr + AW'(1);
    n_inb = !(dir.c_neg && (col_r == '0)) && !(dir.c_pos && (col_r == grid_width - DB'(1))) &&
            !(dir.r_neg && (row_r == '0)) && !(dir.r_pos && (row_r == grid_height - DB'(1)));
  end

  assign diff  = {ctr_h_r[HEIGHT_BITS-1], ctr_h_r} -
                 {h_rdata[HEIGHT_BITS-1], h_rdata[HEIGHT_BITS-1:0]};
  assign adiff = diff[HEIGHT_BITS] ? (~diff + 1'b1) : diff;
  assign pres  = inb_r && s_rdata &&
                 !(33'(adiff) > 33'(unsigned'(max_step)));
  always_comb begin
    p_full    = p_r;
    p_full[7] = pres;
  end
  assign rem       = ctr_s_r && hmt_pkg::thin_remove(p_full, pass_r);
  assign last_cell = (CW'(idx_r) == cnt_r - CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hmt_pkg::S_IDLE: begin
        if (accept) begin
          if (in_kind == hmt_pkg::KIND_READ) state_nxt = hmt_pkg::S_READ;
          else if (in_kind == hmt_pkg::KIND_RUN && cfg_ok) state_nxt = hmt_pkg::S_COPY;
        end
      end
      hmt_pkg::S_READ: state_nxt = hmt_pkg::S_IDLE;
      hmt_pkg::S_COPY: if (sweep_done) state_nxt = hmt_pkg::S_DECIDE;
      hmt_pkg::S_DECIDE: if (step_r == 4'd9 && last_cell) state_nxt = hmt_pkg::S_APPLY;
      hmt_pkg::S_APPLY: begin
        if (sweep_done) begin
          if (!pass_r || (any_r && (iter_inc < 10'(limit)))) state_nxt = hmt_pkg::S_DECIDE;
          else state_nxt = hmt_pkg::S_IDLE;
        end
      end
      default: state_nxt = hmt_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt        = cnt_r;
    ai_nxt         = ai_r;
    pend_nxt       = pend_r;
    pa_nxt         = pa_r;
    idx_nxt        = idx_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    step_nxt       = step_r;
    inb_nxt        = inb_r;
    ctr_h_nxt      = ctr_h_r;
    ctr_s_nxt      = ctr_s_r;
    p_nxt          = p_r;
    pass_nxt       = pass_r;
    any_nxt        = any_r;
    iter_nxt       = iter_r;
    filled_nxt     = filled_r;
    rd_ok_nxt      = rd_ok_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_iter_nxt   = out_iter_r;
    out_skel_nxt   = out_skel_r;
    mc             = '0;
    h_waddr        = AW'(in_cell_index);
    h_wdata        = {in_road, in_height};
    h_raddr        = idx_r;
    s_waddr        = pa_r;
    s_raddr        = idx_r;
    m_waddr        = idx_r;
    m_raddr        = ai_r[AW-1:0];
    unique case (state_r)
      hmt_pkg::S_IDLE: begin
        s_raddr = AW'(in_cell_index);
        if (accept) begin
          unique case (in_kind)
            hmt_pkg::KIND_LOAD: mc.h_we = in_range;
            hmt_pkg::KIND_RUN: begin
              if (!cfg_ok) begin
                out_valid_nxt  = 1'b1;
                out_kind_nxt   = hmt_pkg::REPLY_STATUS;
                out_status_nxt = hmt_pkg::STATUS_INVALID;
                out_iter_nxt   = '0;
                out_skel_nxt   = 1'b0;
              end
              cnt_nxt  = CW'(prod);
              ai_nxt   = '0;
              pend_nxt = 1'b0;
            end
            hmt_pkg::KIND_READ: rd_ok_nxt = in_range && (32'(in_cell_index) < 32'(filled_r));
            default: ;
          endcase
        end
      end
      hmt_pkg::S_READ: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = hmt_pkg::REPLY_READ;
        out_status_nxt = hmt_pkg::STATUS_CONVERGED;
        out_iter_nxt   = '0;
        out_skel_nxt   = rd_ok_r && s_rdata;
      end
      hmt_pkg::S_COPY: begin
        h_raddr   = ai_r[AW-1:0];
        pend_nxt  = issue;
        pa_nxt    = ai_r[AW-1:0];
        if (issue) ai_nxt = ai_r + CW'(1);
        mc.s_we    = pend_r;
        mc.s_wdata = h_rdata[HEIGHT_BITS];
        if (sweep_done) begin
          if (cnt_r > filled_r) filled_nxt = cnt_r;
          idx_nxt  = '0;
          col_nxt  = '0;
          row_nxt  = '0;
          step_nxt = '0;
          pass_nxt = 1'b0;
          any_nxt  = 1'b0;
          iter_nxt = '0;
        end
      end
      hmt_pkg::S_DECIDE: begin
        if (step_r == 4'd0) begin
          h_raddr = idx_r;
          s_raddr = idx_r;
          inb_nxt = 1'b1;
        end else begin
          h_raddr = n_addr;
          s_raddr = n_addr;
          inb_nxt = n_inb;
        end
        if (step_r == 4'd1) begin
          ctr_h_nxt = h_rdata[HEIGHT_BITS-1:0];
          ctr_s_nxt = s_rdata;
        end
        if (step_r >= 4'd2) p_nxt[d_data] = pres;
        if (step_r == 4'd9) begin
          mc.m_we    = 1'b1;
          mc.m_wdata = rem;
          any_nxt    = any_r || rem;
          step_nxt   = '0;
          if (last_cell) begin
            ai_nxt   = '0;
            pend_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + AW'(1);
            if (col_r == grid_width - DB'(1)) begin
              col_nxt = '0;
              row_nxt = row_r + DB'(1);
            end else begin
              col_nxt = col_r + DB'(1);
            end
          end
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      hmt_pkg::S_APPLY: begin
        pend_nxt   = issue;
        pa_nxt     = ai_r[AW-1:0];
        if (issue) ai_nxt = ai_r + CW'(1);
        mc.s_we    = pend_r && m_rdata;
        mc.s_wdata = 1'b0;
        if (sweep_done) begin
          idx_nxt  = '0;
          col_nxt  = '0;
          row_nxt  = '0;
          step_nxt = '0;
          if (!pass_r) begin
            pass_nxt = 1'b1;
          end else begin
            iter_nxt = iter_inc[8:0];
            pass_nxt = 1'b0;
            any_nxt  = 1'b0;
            if (!(any_r && (iter_inc < 10'(limit)))) begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = hmt_pkg::REPLY_STATUS;
              out_status_nxt = any_r ? hmt_pkg::STATUS_LIMIT : hmt_pkg::STATUS_CONVERGED;
              out_iter_nxt   = iter_inc[8:0];
              out_skel_nxt   = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hmt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      filled_r    <= '0;
      pend_r      <= 1'b0;
      ai_r        <= '0;
      cnt_r       <= '0;
      iter_r      <= '0;
      step_r      <= '0;
      pass_r      <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      filled_r    <= filled_nxt;
      pend_r      <= pend_nxt;
      ai_r        <= ai_nxt;
      cnt_r       <= cnt_nxt;
      iter_r      <= iter_nxt;
      step_r      <= step_nxt;
      pass_r      <= pass_nxt;
      any_r       <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r         <= pa_nxt;
    idx_r        <= idx_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    inb_r        <= inb_nxt;
    ctr_h_r      <= ctr_h_nxt;
    ctr_s_r      <= ctr_s_nxt;
    p_r          <= p_nxt;
    rd_ok_r      <= rd_ok_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_iter_r   <= out_iter_nxt;
    out_skel_r   <= out_skel_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_reply_kind      = out_kind_r;
  assign out_status          = out_status_r;
  assign out_iterations_used = out_iter_r;
  assign out_skeleton_bit    = out_skel_r;

endmodule

/* tb/sv/testbench.sv */
// testbench of height_masked_thinning_top: directed table and grids, then random grid
// setups with loads, runs and reads, checked against a thinning predictor
// depends on hmt_pkg and the rtl of height_masked_thinning_top
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hmt_pkg::*;

  typedef struct packed {
    logic       reply_kind;
    logic [1:0] status;
    logic [8:0] iterations;
    logic       skel_bit;
  } reply_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] idx;
    logic        road;
    logic [23:0] hgt;
    bit          typed;
    reply_t      want;
  } row_t;

  localparam int DCOL[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
  localparam int DROW[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic [1:0] in_kind = KIND_LOAD;
  logic [15:0] in_cell_index = '0;
  logic in_road = 1'b0;
  logic signed [23:0] in_height = '0;
  logic out_valid, out_stall = 1'b1;
  logic out_reply_kind, out_skeleton_bit;
  logic [1:0] out_status;
  logic [8:0] out_iterations_used;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0, prdata;

  height_masked_thinning_top dut (.*);

  always #10 clk = ~clk;

  int grid_w, grid_h, errors, items_sent;
  longint step_lim;
  bit road_mem[65536];
  bit skel_mem[65536];
  bit mark_mem[65536];
  logic signed [23:0] hgt_mem[65536];
  reply_t replies_due[$];
  bit burst;

  function automatic bit neighbour_on(int idx, int d);
    int col, row, other;
    longint diff;
    col = idx % grid_w + DCOL[d];
    row = idx / grid_w + DROW[d];
    if (col < 0 || row < 0 || col >= grid_w || row >= grid_h) return 0;
    other = row * grid_w + col;
    diff = longint'(hgt_mem[idx]) - longint'(hgt_mem[other]);
    if (diff < 0) diff = -diff;
    if (diff > step_lim) return 0;
    return skel_mem[other];
  endfunction

  function automatic bit thin_once(int cells, bit pass);
    bit any;
    bit [7:0] p;
    int sum, trans;
    bit side;
    any = 0;
    for (int i = 0; i < cells; i++) begin
      mark_mem[i] = 0;
      if (!skel_mem[i]) continue;
      sum = 0;
      trans = 0;
      for (int d = 0; d < 8; d++) begin
        p[d] = neighbour_on(i, d);
        sum += int'(p[d]);
      end
      for (int d = 0; d < 8; d++)
        if (!p[d] && p[(d + 1) % 8]) trans++;
      if (sum < SUM_MIN || sum > SUM_MAX || trans != 1) continue;
      if (!pass) side = !(p[0] && p[2] && p[4]) && !(p[2] && p[4] && p[6]);
      else side = !(p[0] && p[2] && p[6]) && !(p[0] && p[4] && p[6]);
      if (side) begin
        mark_mem[i] = 1;
        any = 1;
      end
    end
    for (int i = 0; i < cells; i++) begin
      if (mark_mem[i]) skel_mem[i] = 0;
      mark_mem[i] = 0;
    end
    return any;
  endfunction

  function automatic reply_t thin_grid();
    reply_t r;
    int cells, lim, iters;
    bit changed, a, b;
    r = '0;
    r.reply_kind = REPLY_STATUS;
    if (grid_w < 3 || grid_h < 3 || grid_w > MAX_DIM_DEF || grid_h > MAX_DIM_DEF ||
        step_lim <= 0 || grid_w * grid_h > MAX_CELLS_DEF) begin
      r.status = STATUS_INVALID;
      return r;
    end
    cells = grid_w * grid_h;
    for (int i = 0; i < cells; i++) skel_mem[i] = road_mem[i];
    lim = grid_w > grid_h ? grid_w : grid_h;
    iters = 0;
    changed = 1;
    while (changed && iters < lim) begin
      a = thin_once(cells, 0);
      b = thin_once(cells, 1);
      changed = a || b;
      iters++;
    end
    r.status = changed ? STATUS_LIMIT : STATUS_CONVERGED;
    r.iterations = 9'(iters);
    return r;
  endfunction

  function automatic bit model_item(logic [1:0] kind, logic [15:0] idx, logic road,
                                    logic [23:0] hgt, output reply_t r);
    r = '0;
    if (kind == KIND_LOAD) begin
      road_mem[idx] = road;
      hgt_mem[idx] = hgt;
      return 0;
    end
    if (kind == KIND_RUN) begin
      r = thin_grid();
      return 1;
    end
    if (kind == KIND_READ) begin
      r.reply_kind = REPLY_READ;
      r.skel_bit = skel_mem[idx];
      return 1;
    end
    return 0;
  endfunction

  task automatic send(logic [1:0] kind, logic [15:0] idx, logic road, logic [23:0] hgt,
                      bit typed = 0, reply_t want = '0);
    int gap;
    reply_t r;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_cell_index <= idx;
    in_road <= road;
    in_height <= hgt;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (model_item(kind, idx, road, hgt, r)) replies_due.push_back(typed ? want : r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (replies_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] regno, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regno, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (regno == REG_GRID_WIDTH) grid_w = int'(value[8:0]);
    else if (regno == REG_GRID_HEIGHT) grid_h = int'(value[8:0]);
    else if (regno == REG_MAX_STEP) step_lim = longint'($signed(value[23:0]));
  endtask

  task automatic setup(int w, int h, logic [31:0] stp);
    settle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_MAX_STEP, stp);
  endtask

  function automatic logic [23:0] pick_height();
    longint span;
    if (step_lim <= 0 || step_lim > 200000 || $urandom_range(0, 19) == 0)
      return 24'($urandom);
    span = step_lim * 3;
    return 24'($urandom_range(0, int'(span)));
  endfunction

  always @(posedge clk) begin
    reply_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        $error("reply transfer with nothing expected");
        errors++;
      end else begin
        w = replies_due.pop_front();
        if (out_reply_kind !== w.reply_kind) begin
          $error("reply_kind exp %0d got %0d", w.reply_kind, out_reply_kind);
          errors++;
        end
        if (out_status !== w.status) begin
          $error("status exp %0d got %0d", w.status, out_status);
          errors++;
        end
        if (out_iterations_used !== w.iterations) begin
          $error("iterations_used exp %0d got %0d", w.iterations, out_iterations_used);
          errors++;
        end
        if (out_skeleton_bit !== w.skel_bit) begin
          $error("skeleton_bit exp %0d got %0d", w.skel_bit, out_skeleton_bit);
          errors++;
        end
      end
    end
  end

  initial begin
    int n, quiet;
    quiet = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (quiet > 0) begin
        n = 0;
        quiet--;
      end else begin
        n = $urandom_range(0, 15);
        if ($urandom_range(0, 9) == 0) quiet = $urandom_range(5, 30);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #500ms;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    row_t dir[$];
    reply_t rd0, inval;
    int cells, r;
    logic [15:0] ix;
    rd0 = '0;
    rd0.reply_kind = REPLY_READ;
    inval = '0;
    inval.reply_kind = REPLY_STATUS;
    inval.status = STATUS_INVALID;
    grid_w = 0;
    grid_h = 0;
    step_lim = 256;
    errors = 0;
    items_sent = 0;
    burst = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir = '{
      '{KIND_READ, 16'd0, 1'b0, 24'd0, 1, rd0},
      '{KIND_READ, 16'hFFFF, 1'b0, 24'd0, 1, rd0},
      '{KIND_RUN, 16'd0, 1'b0, 24'd0, 1, inval},
      '{2'd3, 16'hFFFF, 1'b1, 24'hFFFFFF, 0, '0},
      '{KIND_LOAD, 16'hFFFF, 1'b1, 24'h7FFFFF, 0, '0},
      '{KIND_LOAD, 16'd0, 1'b1, 24'h800000, 0, '0},
      '{KIND_LOAD, 16'd1, 1'b0, 24'd0, 0, '0},
      '{KIND_READ, 16'hFFFF, 1'b0, 24'd0, 1, rd0},
      '{KIND_RUN, 16'hFFFF, 1'b1, 24'd0, 1, inval},
      '{KIND_READ, 16'd0, 1'b0, 24'd0, 1, rd0}
    };
    foreach (dir[i])
      send(dir[i].kind, dir[i].idx, dir[i].road, dir[i].hgt, dir[i].typed, dir[i].want);

    // full 3x3 block, then a 3x3 with a lone ridge cut off by height
    setup(3, 3, 256);
    for (int i = 0; i < 9; i++) send(KIND_LOAD, 16'(i), 1'b1, 24'd0);
    send(KIND_RUN, 16'd0, 1'b0, 24'd0);
    for (int i = 0; i < 9; i++) send(KIND_READ, 16'(i), 1'b0, 24'd0);
    send(KIND_LOAD, 16'd4, 1'b1, 24'h001000);
    send(KIND_RUN, 16'd0, 1'b0, 24'd0);
    send(KIND_READ, 16'd4, 1'b0, 24'd0);

    // widest and tallest grids, empty mask
    setup(256, 3, 32'h007FFFFF);
    for (int i = 0; i < 768; i++) send(KIND_LOAD, 16'(i), $urandom_range(0, 19) == 0 &&
                                         i % 2 == 0 && (i / 256) == 1 && i % 256 > 2 &&
                                         i % 256 < 250 ? 1'b0 : 1'b0, 24'($urandom));
    send(KIND_RUN, 16'd0, 1'b0, 24'd0);
    send(KIND_READ, 16'd300, 1'b0, 24'd0);
    setup(3, 256, 1);
    send(KIND_RUN, 16'd0, 1'b0, 24'd0);
    send(KIND_READ, 16'd767, 1'b0, 24'd0);

    // invalid setups
    setup(511, 5, 256);
    send(KIND_RUN, 16'd0, 1'b0, 24'd0);
    setup(5, 0, 256);
    send(KIND_RUN, 16'd0, 1'b0, 24'd0);
    setup(257, 256, 256);
    send(KIND_RUN, 16'd0, 1'b0, 24'd0);
    setup(4, 4, 0);
    send(KIND_RUN, 16'd0, 1'b0, 24'd0);
    setup(4, 4, 32'h00800000);
    send(KIND_RUN, 16'd0, 1'b0, 24'd0);

    while (items_sent < 1800) begin
      if ($urandom_range(0, 3) == 0) setup($urandom_range(3, 12), $urandom_range(3, 12),
                                           $urandom_range(0, 1) ? 32'h007FFFFF : 32'd1);
      else setup($urandom_range(3, 8), $urandom_range(3, 8), $urandom_range(1, 600));
      burst = $urandom_range(0, 2) == 0;
      cells = grid_w * grid_h;
      for (int i = 0; i < cells; i++)
        send(KIND_LOAD, 16'(i), $urandom_range(0, 2) != 0, pick_height());
      send(KIND_RUN, 16'd0, 1'b0, 24'd0);
      for (int k = 0; k < 40; k++) begin
        r = $urandom_range(0, 99);
        ix = 16'($urandom_range(0, cells - 1));
        if (r < 45) send(KIND_LOAD, ix, 1'($urandom_range(0, 1)), pick_height());
        else if (r < 52)
          send(KIND_LOAD, 16'($urandom), 1'($urandom_range(0, 1)), 24'($urandom));
        else if (r < 60)
          send(KIND_RUN, 16'($urandom), 1'($urandom_range(0, 1)), 24'($urandom));
        else if (r < 85) send(KIND_READ, ix, 1'b0, 24'd0);
        else if (r < 95)
          send(KIND_READ, 16'($urandom), 1'($urandom_range(0, 1)), 24'($urandom));
        else send(2'd3, 16'($urandom), 1'($urandom_range(0, 1)), 24'($urandom));
      end
    end

    settle();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule
